// File: hw/rtl/conv2d_zero_padded_engine_defines.svh
// ----------------------------------------------------------------------------
// conv2d_zero_padded_engine_defines
// Assertion macros used by the convolution engine RTL.
// ----------------------------------------------------------------------------
`ifndef CONV2D_ZERO_PADDED_ENGINE_DEFINES_SVH
`define CONV2D_ZERO_PADDED_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define C2D_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define C2D_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/c2d_pkg.sv
// ----------------------------------------------------------------------------
// c2d_pkg
// Constants, widths and codes of the zero-padded 2D convolution engine.
// ----------------------------------------------------------------------------
package c2d_pkg;

	localparam int WINDOW       = 3;
	localparam int CHANNELS     = 3;
	localparam int MAX_DIM      = 64;
	localparam int MAX_FEATURES = 8;

	localparam int TAPS      = WINDOW * WINDOW * CHANNELS;
	localparam int HALF      = WINDOW / 2;
	localparam int IMG_DEPTH = MAX_DIM * MAX_DIM * CHANNELS;

	// Field widths
	localparam int CMD_W  = 2;
	localparam int DIM_W  = 6;
	localparam int CH_W   = 2;
	localparam int FEAT_W = 3;
	localparam int TAP_W  = 5;
	localparam int VAL_W  = 16;
	localparam int PROD_W = 2 * VAL_W;
	localparam int SUM_W  = 37;

	// Register widths
	localparam int LIM_W = 7;
	localparam int FC_W  = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;

	// Internal widths
	localparam int IMG_AW = $clog2(IMG_DEPTH);
	localparam int WGT_AW = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int WIN_W  = $clog2(WINDOW + 1);
	localparam int CIDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int FIDX_W = $clog2(MAX_FEATURES + 1);

	// Commands
	localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_WEIGHT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT = 2'd2;

	// Reset values
	localparam logic [LIM_W-1:0] ROWS_RST   = 7'd64;
	localparam logic [LIM_W-1:0] COLS_RST   = 7'd64;
	localparam logic [FC_W-1:0]  FCOUNT_RST = 4'd3;

	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

endpackage

// File: hw/rtl/c2d_ram.sv
// ----------------------------------------------------------------------------
// c2d_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module c2d_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/conv2d_zero_padded_engine.sv
// ----------------------------------------------------------------------------
// conv2d_zero_padded_engine
// Multi-feature 3x3x3 convolution with zero padding over a stored image.
// ----------------------------------------------------------------------------
// A sample or weight write command is written into its store when taken. A
// compute command walks the 27 taps of the window, one image RAM read per
// cycle (the single read port of the image RAM sets this), with all features
// multiplied and summed in parallel from one weight RAM per feature; after
// the walk the read, multiply and accumulate stages drain, and the sums leave
// one per cycle while the output register is free. The next command is taken
// once the last sum is loaded into the output register, or after the drain
// when the feature count is zero. Padding taps skip their contribution. Both
// stores power up undefined and need no clearing pass. Configuration writes are taken in any cycle.
// ----------------------------------------------------------------------------
`include "conv2d_zero_padded_engine_defines.svh"

module conv2d_zero_padded_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	// Configuration
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [c2d_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [c2d_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Commands
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [c2d_pkg::CMD_W-1:0]           command,
	input  logic [c2d_pkg::DIM_W-1:0]           row,
	input  logic [c2d_pkg::DIM_W-1:0]           col,
	input  logic [c2d_pkg::CH_W-1:0]            channel,
	input  logic [c2d_pkg::FEAT_W-1:0]          feature,
	input  logic [c2d_pkg::TAP_W-1:0]           tap,
	input  logic signed [c2d_pkg::VAL_W-1:0]    value,
	// Results
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [c2d_pkg::FEAT_W-1:0]          out_feature,
	output logic signed [c2d_pkg::SUM_W-1:0]    sum,
	output logic                                last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_EMIT  = 2'd3;

	localparam int LIM_W  = c2d_pkg::LIM_W;
	localparam int FIDX_W = c2d_pkg::FIDX_W;
	localparam int NF     = c2d_pkg::MAX_FEATURES;

	logic [1:0]                        state_q;
	logic [LIM_W-1:0]                  rows_q;
	logic [LIM_W-1:0]                  cols_q;
	logic [c2d_pkg::FC_W-1:0]          fcount_q;

	logic [c2d_pkg::DIM_W-1:0]         row_q;
	logic [c2d_pkg::DIM_W-1:0]         col_q;
	logic [c2d_pkg::WIN_W-1:0]         x_q;
	logic [c2d_pkg::WIN_W-1:0]         y_q;
	logic [c2d_pkg::CIDX_W-1:0]        c_q;
	logic [c2d_pkg::WGT_AW-1:0]        tap_q;
	logic [FIDX_W-1:0]                 f_q;

	logic                              v_s1;
	logic                              pv_s2;
	c2d_pkg::prod_t                    prod_s2 [NF];
	c2d_pkg::sum_t                     acc_q [NF];

	logic                              out_valid_q;
	logic [c2d_pkg::FEAT_W-1:0]        out_feature_q;
	c2d_pkg::sum_t                     sum_q;
	logic                              last_q;

	logic                              in_xfer;
	logic                              start;
	logic                              run;
	logic                              last_tap;
	logic                              load;
	logic                              pipe_empty;
	logic [LIM_W-1:0]                  rlim;
	logic [LIM_W-1:0]                  clim;
	logic [FIDX_W-1:0]                 nf;
	logic [LIM_W-1:0]                  r_u;
	logic [LIM_W-1:0]                  k_u;
	logic [LIM_W-1:0]                  r_off;
	logic [LIM_W-1:0]                  k_off;
	logic                              inb;
	logic                              img_we;
	logic [c2d_pkg::IMG_AW-1:0]        img_waddr;
	logic [c2d_pkg::IMG_AW-1:0]        img_raddr;
	logic [c2d_pkg::VAL_W-1:0]         img_rd;
	logic [c2d_pkg::VAL_W-1:0]         wgt_rd [NF];

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign start     = in_xfer && (command == c2d_pkg::CMD_COMPUTE);
	assign run       = (state_q == ST_RUN);
	assign last_tap  = (tap_q == c2d_pkg::WGT_AW'(c2d_pkg::TAPS - 1));
	assign pipe_empty = !v_s1 && !pv_s2;
	assign load      = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	// Saturate the padding bounds and the feature count
	assign rlim = (rows_q > LIM_W'(c2d_pkg::MAX_DIM)) ? LIM_W'(c2d_pkg::MAX_DIM) : rows_q;
	assign clim = (cols_q > LIM_W'(c2d_pkg::MAX_DIM)) ? LIM_W'(c2d_pkg::MAX_DIM) : cols_q;
	assign nf   = (fcount_q > c2d_pkg::FC_W'(NF)) ? FIDX_W'(NF) : FIDX_W'(fcount_q);

	// Tap position, offset by half a window so that it never goes negative
	assign r_u   = LIM_W'(row_q) + LIM_W'(x_q);
	assign k_u   = LIM_W'(col_q) + LIM_W'(y_q);
	assign r_off = r_u - LIM_W'(c2d_pkg::HALF);
	assign k_off = k_u - LIM_W'(c2d_pkg::HALF);
	assign inb   = (r_u >= LIM_W'(c2d_pkg::HALF)) && (k_u >= LIM_W'(c2d_pkg::HALF))
		&& (r_off < rlim) && (k_off < clim);

	assign img_we = in_xfer && (command == c2d_pkg::CMD_SAMPLE)
		&& (32'(channel) < c2d_pkg::CHANNELS);
	assign img_waddr = c2d_pkg::IMG_AW'((32'(row) * c2d_pkg::MAX_DIM + 32'(col))
		* c2d_pkg::CHANNELS + 32'(channel));
	assign img_raddr = c2d_pkg::IMG_AW'((32'(r_off[c2d_pkg::DIM_W-1:0]) * c2d_pkg::MAX_DIM
		+ 32'(k_off[c2d_pkg::DIM_W-1:0])) * c2d_pkg::CHANNELS + 32'(c_q));

	c2d_ram #(
		.WIDTH (c2d_pkg::VAL_W),
		.DEPTH (c2d_pkg::IMG_DEPTH)
	) u_img_ram (
		.clk   (clk),
		.we    (img_we),
		.waddr (img_waddr),
		.wdata (value),
		.raddr (img_raddr),
		.rdata (img_rd)
	);

	// One weight RAM per feature, so all features see their tap at once
	for (genvar f = 0; f < NF; f++) begin : g_feat
		logic wgt_we;

		assign wgt_we = in_xfer && (command == c2d_pkg::CMD_WEIGHT)
			&& (32'(feature) == f) && (32'(tap) < c2d_pkg::TAPS);

		c2d_ram #(
			.WIDTH (c2d_pkg::VAL_W),
			.DEPTH (c2d_pkg::TAPS)
		) u_wgt_ram (
			.clk   (clk),
			.we    (wgt_we),
			.waddr (c2d_pkg::WGT_AW'(tap)),
			.wdata (value),
			.raddr (tap_q),
			.rdata (wgt_rd[f])
		);

		always_ff @(posedge clk) begin
			prod_s2[f] <= $signed(img_rd) * $signed(wgt_rd[f]);
			if (start) begin
				acc_q[f] <= '0;
			end else if (pv_s2) begin
				acc_q[f] <= acc_q[f] + c2d_pkg::sum_t'(prod_s2[f]);
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q   <= c2d_pkg::ROWS_RST;
			cols_q   <= c2d_pkg::COLS_RST;
			fcount_q <= c2d_pkg::FCOUNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				c2d_pkg::CFG_IMAGE_ROWS:    rows_q   <= cfg_data;
				c2d_pkg::CFG_IMAGE_COLS:    cols_q   <= cfg_data;
				c2d_pkg::CFG_FEATURE_COUNT: fcount_q <= cfg_data[c2d_pkg::FC_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer: walk the taps, drain the pipeline, send the sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			x_q     <= '0;
			y_q     <= '0;
			c_q     <= '0;
			tap_q   <= '0;
			f_q     <= '0;
			v_s1    <= 1'b0;
			pv_s2   <= 1'b0;
		end else begin
			v_s1  <= run && inb;
			pv_s2 <= v_s1;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
						row_q   <= row;
						col_q   <= col;
						x_q     <= '0;
						y_q     <= '0;
						c_q     <= '0;
						tap_q   <= '0;
					end
				end
				ST_RUN: begin
					tap_q <= tap_q + 1'b1;
					if (32'(c_q) == c2d_pkg::CHANNELS - 1) begin
						c_q <= '0;
						if (32'(y_q) == c2d_pkg::WINDOW - 1) begin
							y_q <= '0;
							x_q <= x_q + 1'b1;
						end else begin
							y_q <= y_q + 1'b1;
						end
					end else begin
						c_q <= c_q + 1'b1;
					end
					if (last_tap) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (pipe_empty) begin
						f_q     <= '0;
						state_q <= (nf == '0) ? ST_IDLE : ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (load) begin
						f_q <= f_q + 1'b1;
						if (f_q + 1'b1 == nf) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_feature_q <= f_q[c2d_pkg::FEAT_W-1:0];
			sum_q         <= acc_q[f_q[c2d_pkg::FEAT_W-1:0]];
			last_q        <= (f_q + 1'b1 == nf);
		end
	end

	assign out_valid   = out_valid_q;
	assign out_feature = out_feature_q;
	assign sum         = sum_q;
	assign last        = last_q;

	`C2D_ASSERT_IMPL(a_idle_pipe_empty, in_ready, !v_s1 && !pv_s2, "pipeline busy while idle")
	`C2D_ASSERT_IMPL(a_emit_in_range, state_q == ST_EMIT, f_q < nf && nf != '0, "feature index out of range")
	`C2D_ASSERT_NEXT(a_walk_ends, run && last_tap, state_q == ST_DRAIN && tap_q == '0 || state_q == ST_DRAIN, "tap walk did not end")
	`C2D_ASSERT_NEXT(a_start_runs, start, state_q == ST_RUN && tap_q == '0, "compute did not start at tap zero")

endmodule

// File: tb/sv/conv2d_zero_padded_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv2d_zero_padded_engine_tb
// Self-checking bench for the zero-padded multi-feature convolution engine.
// Commands go in over a valid/ready channel. A predictor keeps its own image
// and weight stores and register copies, and works out the expected feature
// sums for every accepted compute. A checker compares each result transfer
// with the oldest expected sum. Stores are always written before a compute
// can read them. Directed tests cover reset values, extreme sums, ignored
// commands and register limits. Random phases run under several register
// settings, followed by a long output stall and a stretch without gaps.
// ----------------------------------------------------------------------------
module conv2d_zero_padded_engine_tb;
	import c2d_pkg::*;

	localparam int RESET_CYCLES     = 12;
	localparam int DRAIN_CYCLES     = 48;
	localparam int END_CYCLES       = 64;
	localparam int STUCK_LIMIT      = 4000;
	localparam int HOLD_CYCLES      = 400;
	localparam int PHASE_ITEMS      = 6;
	localparam int STEADY_ITEMS     = 16;
	localparam int PRESSURE_ITEMS   = 10;
	localparam int REPORT_LIMIT     = 10;
	localparam int COEF_DEPTH       = MAX_FEATURES * TAPS;

	localparam logic [CMD_W-1:0]     CMD_NONE   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7FFF;

	typedef struct {
		logic [CMD_W-1:0]        cmd;
		logic [DIM_W-1:0]        row;
		logic [DIM_W-1:0]        col;
		logic [CH_W-1:0]         channel;
		logic [FEAT_W-1:0]       feature;
		logic [TAP_W-1:0]        tap;
		logic signed [VAL_W-1:0] value;
	} conv_cmd_t;

	typedef struct {
		logic [FEAT_W-1:0] feat;
		sum_t              total;
		logic              is_last;
	} feat_sum_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [CMD_W-1:0]        command = '0;
	logic [DIM_W-1:0]        row = '0;
	logic [DIM_W-1:0]        col = '0;
	logic [CH_W-1:0]         channel = '0;
	logic [FEAT_W-1:0]       feature = '0;
	logic [TAP_W-1:0]        tap = '0;
	logic signed [VAL_W-1:0] value = '0;

	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [FEAT_W-1:0] out_feature;
	sum_t              sum;
	logic              last;

	// Predictor state
	logic signed [VAL_W-1:0] pix_mem [IMG_DEPTH];
	bit                      pix_set [IMG_DEPTH];
	logic signed [VAL_W-1:0] coef_mem [COEF_DEPTH];
	bit                      coef_set [COEF_DEPTH];
	logic [LIM_W-1:0]        rows_reg = ROWS_RST;
	logic [LIM_W-1:0]        cols_reg = COLS_RST;
	logic [FC_W-1:0]         fcount_reg = FCOUNT_RST;

	feat_sum_t pending_sums [$];
	feat_sum_t head_sum;

	int  err_count = 0;
	int  sent_items = 0;
	int  stuck_cycles = 0;
	int  sink_hold = 0;
	int  sink_stall = 0;
	bit  sink_gaps = 1'b1;
	bit  src_gaps = 1'b1;

	conv2d_zero_padded_engine dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.command     (command),
		.row         (row),
		.col         (col),
		.channel     (channel),
		.feature     (feature),
		.tap         (tap),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_feature (out_feature),
		.sum         (sum),
		.last        (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic int eff_rows();
		return (rows_reg > MAX_DIM) ? MAX_DIM : int'(rows_reg);
	endfunction

	function automatic int eff_cols();
		return (cols_reg > MAX_DIM) ? MAX_DIM : int'(cols_reg);
	endfunction

	function automatic int eff_features();
		return (fcount_reg > MAX_FEATURES) ? MAX_FEATURES : int'(fcount_reg);
	endfunction

	function automatic int pix_addr(input int r, input int k, input int ch);
		return (r * MAX_DIM + k) * CHANNELS + ch;
	endfunction

	function automatic int coef_addr(input int f, input int t);
		return f * TAPS + t;
	endfunction

	function automatic void predict_window_sums(input int prow, input int pcol);
		int        rl;
		int        cl;
		int        nf;
		int        r;
		int        k;
		longint    acc;
		feat_sum_t e;
		rl = eff_rows();
		cl = eff_cols();
		nf = eff_features();
		for (int f = 0; f < nf; f++) begin
			acc = 0;
			for (int x = 0; x < WINDOW; x++) begin
				for (int y = 0; y < WINDOW; y++) begin
					r = prow + x - HALF;
					k = pcol + y - HALF;
					// padding tap: contributes nothing
					if (r < 0 || k < 0 || r >= rl || k >= cl)
						continue;
					for (int ch = 0; ch < CHANNELS; ch++)
						acc += longint'(pix_mem[pix_addr(r, k, ch)]) *
							longint'(coef_mem[coef_addr(f, (x * WINDOW + y) * CHANNELS + ch)]);
				end
			end
			e.feat    = f[FEAT_W-1:0];
			e.total   = acc[SUM_W-1:0];
			e.is_last = (f == nf - 1);
			pending_sums.push_back(e);
		end
	endfunction

	// Returns 1 when the command has an effect on the block
	function automatic bit apply_cmd(input conv_cmd_t c);
		case (c.cmd)
			CMD_SAMPLE: begin
				if (c.channel >= CHANNELS)
					return 1'b0;
				pix_mem[pix_addr(c.row, c.col, c.channel)] = c.value;
				pix_set[pix_addr(c.row, c.col, c.channel)] = 1'b1;
				return 1'b1;
			end
			CMD_WEIGHT: begin
				if (c.tap >= TAPS)
					return 1'b0;
				coef_mem[coef_addr(c.feature, c.tap)] = c.value;
				coef_set[coef_addr(c.feature, c.tap)] = 1'b1;
				return 1'b1;
			end
			CMD_COMPUTE: begin
				predict_window_sums(c.row, c.col);
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------
	function automatic conv_cmd_t rand_item();
		conv_cmd_t c;
		c.cmd     = CMD_W'($urandom);
		c.row     = DIM_W'($urandom);
		c.col     = DIM_W'($urandom);
		c.channel = CH_W'($urandom);
		c.feature = FEAT_W'($urandom);
		c.tap     = TAP_W'($urandom);
		c.value   = VAL_W'($urandom);
		return c;
	endfunction

	// Entered anywhere after a rising edge; returns at the accepting edge.
	task automatic send_cmd(input conv_cmd_t c);
		@(negedge clk);
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= c.cmd;
		row      <= c.row;
		col      <= c.col;
		channel  <= c.channel;
		feature  <= c.feature;
		tap      <= c.tap;
		value    <= c.value;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (apply_cmd(c))
			sent_items++;
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_IMAGE_ROWS:    rows_reg = data;
			CFG_IMAGE_COLS:    cols_reg = data;
			CFG_FEATURE_COUNT: fcount_reg = data[FC_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait for every expected sum, then let the block go quiet
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic configure(input int rows_val, input int cols_val, input int fc_val);
		logic [CFG_DATA_W-1:0] d;
		settle();
		cfg_write(CFG_IMAGE_ROWS, rows_val[CFG_DATA_W-1:0]);
		cfg_write(CFG_IMAGE_COLS, cols_val[CFG_DATA_W-1:0]);
		// upper data bits are don't-care for the feature count
		d = CFG_DATA_W'($urandom);
		d[FC_W-1:0] = fc_val[FC_W-1:0];
		cfg_write(CFG_FEATURE_COUNT, d);
	endtask

	// Write every store entry a compute at (prow, pcol) could touch
	task automatic prepare_window(input int prow, input int pcol);
		int        r;
		int        k;
		conv_cmd_t w;
		for (int x = 0; x < WINDOW; x++) begin
			for (int y = 0; y < WINDOW; y++) begin
				r = prow + x - HALF;
				k = pcol + y - HALF;
				if (r < 0 || k < 0 || r >= MAX_DIM || k >= MAX_DIM)
					continue;
				for (int ch = 0; ch < CHANNELS; ch++) begin
					if (!pix_set[pix_addr(r, k, ch)]) begin
						w = rand_item();
						w.cmd     = CMD_SAMPLE;
						w.row     = r[DIM_W-1:0];
						w.col     = k[DIM_W-1:0];
						w.channel = ch[CH_W-1:0];
						send_cmd(w);
					end
				end
			end
		end
		for (int f = 0; f < eff_features(); f++) begin
			for (int t = 0; t < TAPS; t++) begin
				if (!coef_set[coef_addr(f, t)]) begin
					w = rand_item();
					w.cmd     = CMD_WEIGHT;
					w.feature = f[FEAT_W-1:0];
					w.tap     = t[TAP_W-1:0];
					send_cmd(w);
				end
			end
		end
	endtask

	task automatic compute_at(input int prow, input int pcol);
		conv_cmd_t w;
		prepare_window(prow, pcol);
		w = rand_item();
		w.cmd = CMD_COMPUTE;
		w.row = prow[DIM_W-1:0];
		w.col = pcol[DIM_W-1:0];
		send_cmd(w);
	endtask

	task automatic write_sample(input int r, input int k, input int ch,
			input logic signed [VAL_W-1:0] v);
		conv_cmd_t w;
		w = rand_item();
		w.cmd     = CMD_SAMPLE;
		w.row     = r[DIM_W-1:0];
		w.col     = k[DIM_W-1:0];
		w.channel = ch[CH_W-1:0];
		w.value   = v;
		send_cmd(w);
	endtask

	task automatic write_weight(input int f, input int t, input logic signed [VAL_W-1:0] v);
		conv_cmd_t w;
		w = rand_item();
		w.cmd     = CMD_WEIGHT;
		w.feature = f[FEAT_W-1:0];
		w.tap     = t[TAP_W-1:0];
		w.value   = v;
		send_cmd(w);
	endtask

	// Random mix over a patch of the image that the current sizes make useful
	task automatic run_mix(input int budget);
		int        stop_at;
		int        rl;
		int        cl;
		int        r0;
		int        c0;
		int        rspan;
		int        cspan;
		int        pick;
		conv_cmd_t w;
		stop_at = sent_items + budget;
		rl = eff_rows();
		cl = eff_cols();
		if (rl <= 10) begin
			r0 = 0;
			rspan = rl + 2;
		end else begin
			r0 = $urandom_range(0, 1) ? 0 : rl - 8;
			rspan = (MAX_DIM - r0 < 10) ? MAX_DIM - r0 : 10;
		end
		if (cl <= 10) begin
			c0 = 0;
			cspan = cl + 2;
		end else begin
			c0 = $urandom_range(0, 1) ? 0 : cl - 8;
			cspan = (MAX_DIM - c0 < 10) ? MAX_DIM - c0 : 10;
		end
		while (sent_items < stop_at) begin
			pick = $urandom_range(0, 99);
			w = rand_item();
			if (pick < 40) begin
				compute_at(r0 + $urandom_range(0, rspan - 1), c0 + $urandom_range(0, cspan - 1));
			end else if (pick < 70) begin
				w.cmd     = CMD_SAMPLE;
				w.row     = DIM_W'(r0 + $urandom_range(0, rspan - 1));
				w.col     = DIM_W'(c0 + $urandom_range(0, cspan - 1));
				w.channel = CH_W'($urandom_range(0, CHANNELS - 1));
				send_cmd(w);
			end else if (pick < 85) begin
				w.cmd = CMD_WEIGHT;
				w.tap = TAP_W'($urandom_range(0, TAPS - 1));
				send_cmd(w);
			end else begin
				// noise: commands the block must drop
				case ($urandom_range(0, 2))
					0: w.cmd = CMD_NONE;
					1: begin
						w.cmd     = CMD_SAMPLE;
						w.channel = CH_W'($urandom_range(CHANNELS, (1 << CH_W) - 1));
					end
					default: begin
						w.cmd = CMD_WEIGHT;
						w.tap = TAP_W'($urandom_range(TAPS, (1 << TAP_W) - 1));
					end
				endcase
				send_cmd(w);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	task automatic test_reset_defaults();
		// 64x64 image and three features straight out of reset
		compute_at(0, 0);
		compute_at(MAX_DIM - 1, MAX_DIM - 1);
		compute_at(MAX_DIM - 1, 0);
	endtask

	task automatic test_extreme_sums();
		configure(3, 3, 2);
		for (int r = 0; r < 3; r++)
			for (int k = 0; k < 3; k++)
				for (int ch = 0; ch < CHANNELS; ch++)
					write_sample(r, k, ch, VAL_MIN);
		// feature 0 reaches the largest sum, feature 1 the most negative
		for (int t = 0; t < TAPS; t++) begin
			write_weight(0, t, VAL_MIN);
			write_weight(1, t, VAL_MAX);
		end
		compute_at(1, 1);
		compute_at(0, 0);
		compute_at(2, 2);
		write_sample(1, 1, 0, VAL_MAX);
		compute_at(1, 1);
	endtask

	task automatic test_ignored_items();
		conv_cmd_t w;
		configure(4, 4, 2);
		compute_at(1, 1);
		w = rand_item();
		w.cmd = CMD_NONE;
		w.row = DIM_W'(1);
		w.col = DIM_W'(1);
		send_cmd(w);
		w = rand_item();
		w.cmd     = CMD_SAMPLE;
		w.row     = DIM_W'(1);
		w.col     = DIM_W'(1);
		w.channel = CH_W'((1 << CH_W) - 1);
		send_cmd(w);
		w = rand_item();
		w.cmd     = CMD_WEIGHT;
		w.feature = '0;
		w.tap     = TAP_W'(TAPS);
		send_cmd(w);
		w.tap = TAP_W'((1 << TAP_W) - 1);
		send_cmd(w);
		compute_at(1, 1);
	endtask

	task automatic test_register_limits();
		configure(0, 4, 2);
		compute_at(0, 0);
		compute_at(2, 2);
		configure(4, 0, 1);
		compute_at(1, 1);
		// feature count zero: compute yields nothing
		configure(4, 4, 0);
		compute_at(1, 1);
		configure(4, 4, 15);
		compute_at(3, 3);
		configure(127, 100, 9);
		compute_at(MAX_DIM - 1, MAX_DIM - 2);
		compute_at(MAX_DIM - 2, MAX_DIM - 1);
		configure(1, 1, 1);
		compute_at(0, 0);
		// sample stored outside the image, then brought inside
		configure(2, 2, 1);
		write_sample(2, 2, 0, VAL_W'($urandom));
		compute_at(3, 3);
		compute_at(2, 2);
		configure(3, 3, 1);
		compute_at(2, 2);
		settle();
		cfg_write(CFG_UNUSED, CFG_DATA_W'($urandom));
		compute_at(2, 2);
	endtask

	task automatic test_random_phases();
		int rows_tab [7] = '{5, 1, 64, 127, 8, 2, 64};
		int cols_tab [7] = '{4, 1, 64, 9, 64, 6, 3};
		int fc_tab   [7] = '{3, 8, 1, 15, 2, 0, 5};
		for (int p = 0; p < 7; p++) begin
			configure(rows_tab[p], cols_tab[p], fc_tab[p]);
			run_mix(PHASE_ITEMS);
		end
	endtask

	task automatic test_output_backpressure();
		configure(4, 4, 8);
		src_gaps = 1'b0;
		@(posedge clk);
		sink_hold = HOLD_CYCLES;
		for (int i = 0; i < PRESSURE_ITEMS; i++)
			compute_at($urandom_range(0, 5), $urandom_range(0, 5));
		src_gaps = 1'b1;
	endtask

	task automatic test_steady_stream();
		configure(6, 5, 4);
		src_gaps  = 1'b0;
		sink_gaps = 1'b0;
		run_mix(STEADY_ITEMS);
	endtask

	// ------------------------------------------------------------------
	// Result side
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			out_ready <= 1'b0;
			sink_hold--;
		end else if (sink_stall > 0) begin
			out_ready <= 1'b0;
			sink_stall--;
		end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
			out_ready <= 1'b0;
			sink_stall = $urandom_range(0, 14);
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_sums.size() == 0) begin
				if (err_count < REPORT_LIMIT)
					$display("unexpected sum: feature %0d sum %0d last %0b",
						out_feature, sum, last);
				err_count++;
			end else begin
				head_sum = pending_sums.pop_front();
				if (out_feature !== head_sum.feat || sum !== head_sum.total ||
						last !== head_sum.is_last) begin
					if (err_count < REPORT_LIMIT)
						$display("sum mismatch: exp feature %0d sum %0d last %0b, got feature %0d sum %0d last %0b",
							head_sum.feat, head_sum.total, head_sum.is_last,
							out_feature, sum, last);
					err_count++;
				end
			end
		end
	end

	// Watchdog: no transfer on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready))
			stuck_cycles = 0;
		else
			stuck_cycles++;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("conv2d_zero_padded_engine_tb NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_extreme_sums();
		test_ignored_items();
		test_register_limits();
		test_random_phases();
		test_output_backpressure();
		test_steady_stream();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_sums.size() != 0)
			@(negedge clk);
		repeat (END_CYCLES) @(negedge clk);
		if (err_count == 0)
			$display("conv2d_zero_padded_engine_tb OK");
		else
			$display("conv2d_zero_padded_engine_tb NOT OK");
		$finish;
	end

endmodule
